>>> hdl/psu_pkg.sv
package psu_pkg;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top-level parameters.
    localparam int PIXEL_BYTES_DEF = 4;
    localparam int MAX_WIDTH_DEF   = 4096;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Scanline filter types.
    typedef enum logic [BYTE_W-1:0] {
        FILT_NONE    = 8'd0,
        FILT_SUB     = 8'd1,
        FILT_UP      = 8'd2,
        FILT_AVERAGE = 8'd3,
        FILT_PAETH   = 8'd4
    } t_filter;

endpackage

>>> hdl/psu_ram.sv
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; a read of the address being written returns old data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/psu_pred.sv
module psu_pred
    import psu_pkg::*;
(
    input  logic [BYTE_W-1:0] i_left,
    input  logic [BYTE_W-1:0] i_up,
    input  logic [BYTE_W-1:0] i_upleft,
    input  logic [BYTE_W-1:0] i_filter,
    output logic [BYTE_W-1:0] o_pred,
    output logic              o_unknown
);

    logic signed [BYTE_W+1:0] d_pa;
    logic signed [BYTE_W+1:0] d_pb;
    logic signed [BYTE_W+1:0] d_pc;
    logic        [BYTE_W+1:0] abs_pa;
    logic        [BYTE_W+1:0] abs_pb;
    logic        [BYTE_W+1:0] abs_pc;
    logic        [BYTE_W-1:0] paeth;
    logic        [BYTE_W:0]   avg_sum;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
    always_comb begin
        d_pa = $signed({2'b00, i_up}) - $signed({2'b00, i_upleft});
        d_pb = $signed({2'b00, i_left}) - $signed({2'b00, i_upleft});
        d_pc = $signed({2'b00, i_left}) + $signed({2'b00, i_up})
             - $signed({1'b0, i_upleft, 1'b0});
        abs_pa = (d_pa < 0) ? $unsigned(-d_pa) : $unsigned(d_pa);
        abs_pb = (d_pb < 0) ? $unsigned(-d_pb) : $unsigned(d_pb);
        abs_pc = (d_pc < 0) ? $unsigned(-d_pc) : $unsigned(d_pc);
        priority if (abs_pa <= abs_pb && abs_pa <= abs_pc) begin
            paeth = i_left;
        end else if (abs_pb <= abs_pc) begin
            paeth = i_up;
        end else begin
            paeth = i_upleft;
        end
    end

    // Average rounds down.
    assign avg_sum = {1'b0, i_left} + {1'b0, i_up};

    // Predictor selection by the row's filter type.
    always_comb begin
        o_unknown = 1'b0;
        unique case (t_filter'(i_filter))
            FILT_NONE:    o_pred = '0;
            FILT_SUB:     o_pred = i_left;
            FILT_UP:      o_pred = i_up;
            FILT_AVERAGE: o_pred = avg_sum[BYTE_W:1];
            FILT_PAETH:   o_pred = paeth;
            default: begin
                o_pred    = '0;
                o_unknown = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/png_scanline_unfilter.sv
// Throughput: one byte per cycle unless the output stalls; the line store is read
// one position ahead, so its registered read port never holds a byte back. Each
// sample byte's result is registered as it is taken; filter-type bytes give no result.
// Reset (synchronous, active low) clears the counters, neighbour registers and output
// valid; the line store is not cleared, and the first row of an image reads zero above.
module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int PIXEL_BYTES = PIXEL_BYTES_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_filtered_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_pixel_byte,
    output logic                  o_end_of_row,
    output logic                  o_end_of_image,
    output logic                  o_unknown_filter
);

    localparam int DEPTH  = MAX_WIDTH * PIXEL_BYTES;
    localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LANE_W = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;
    localparam int CMP_W  = (POS_W + 1 > WIDTH_W) ? POS_W + 1 : WIDTH_W;

    // Configuration registers.
    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;

    // Scan position state.
    logic                r_at_filter;
    logic [BYTE_W-1:0]   r_row_filter;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [LANE_W-1:0]   r_lane;
    logic [HEIGHT_W-1:0] r_row_count;
    logic [BYTE_W-1:0]   r_left   [PIXEL_BYTES];
    logic [BYTE_W-1:0]   r_upleft [PIXEL_BYTES];

    // Line store forwarding for a one-byte row.
    logic                r_byp_valid;
    logic [BYTE_W-1:0]   r_byp_data;
    logic [BYTE_W-1:0]   store_rdata;

    // Output register.
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_eor;
    logic                r_out_eoi;
    logic                r_out_unknown;

    logic                accept;
    logic                sample_acc;
    logic [CMP_W-1:0]    width_ext;
    logic [CMP_W-1:0]    eff_width;
    logic [CMP_W-1:0]    row_len;
    logic [CMP_W-1:0]    pos_next;
    logic [HEIGHT_W:0]   rows_done;
    logic [HEIGHT_W:0]   eff_height;
    logic                eor;
    logic                eoi;
    logic [BYTE_W-1:0]   nb_left;
    logic [BYTE_W-1:0]   nb_up;
    logic [BYTE_W-1:0]   nb_upleft;
    logic [BYTE_W-1:0]   pred;
    logic                unknown;
    logic [BYTE_W-1:0]   res;

    // Transfer control: the input stalls only while a result waits and is held off.
    assign o_stall    = r_out_valid && i_stall;
    assign accept     = i_valid && !o_stall;
    assign sample_acc = accept && !r_at_filter;

    // Row length and end-of-row / end-of-image decisions.
    always_comb begin
        width_ext = CMP_W'(r_image_width);
        if (width_ext == '0) begin
            eff_width = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        row_len    = CMP_W'(eff_width * PIXEL_BYTES);
        pos_next   = CMP_W'(r_pos) + CMP_W'(1);
        eor        = pos_next >= row_len;
        rows_done  = {1'b0, r_row_count} + (HEIGHT_W+1)'(1);
        eff_height = (r_image_height == '0) ? (HEIGHT_W+1)'(1) : {1'b0, r_image_height};
        eoi        = eor && (rows_done >= eff_height);
    end

    // Neighbour bytes for the current sample.
    always_comb begin
        nb_left   = r_left[r_lane];
        nb_upleft = r_upleft[r_lane];
        if (r_row_count == '0) begin
            nb_up = '0;
        end else if (r_byp_valid) begin
            nb_up = r_byp_data;
        end else begin
            nb_up = store_rdata;
        end
    end

    psu_pred u_pred (
        .i_left    (nb_left),
        .i_up      (nb_up),
        .i_upleft  (nb_upleft),
        .i_filter  (r_row_filter),
        .o_pred    (pred),
        .o_unknown (unknown)
    );

    assign res = i_filtered_byte + pred;

    // Next store position, used as the read-ahead address.
    always_comb begin
        n_pos = r_pos;
        if (sample_acc) begin
            n_pos = eor ? '0 : POS_W'(pos_next);
        end
    end

    psu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (sample_acc),
        .i_waddr (r_pos),
        .i_wdata (res),
        .i_raddr (n_pos),
        .o_rdata (store_rdata)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_W'(1);
            r_image_height <= HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan state and neighbour registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_filter  <= 1'b1;
            r_row_filter <= '0;
            r_pos        <= '0;
            r_lane       <= '0;
            r_row_count  <= '0;
            r_byp_valid  <= 1'b0;
            for (int i = 0; i < PIXEL_BYTES; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else begin
            r_byp_valid <= sample_acc && (n_pos == r_pos);
            if (accept && r_at_filter) begin
                r_row_filter <= i_filtered_byte;
                r_at_filter  <= 1'b0;
                for (int i = 0; i < PIXEL_BYTES; i++) begin
                    r_left[i]   <= '0;
                    r_upleft[i] <= '0;
                end
            end else if (sample_acc) begin
                r_left[r_lane]   <= res;
                r_upleft[r_lane] <= nb_up;
                r_pos            <= n_pos;
                if (eor) begin
                    r_at_filter <= 1'b1;
                    r_lane      <= '0;
                    r_row_count <= eoi ? '0 : rows_done[HEIGHT_W-1:0];
                end else if (r_lane == LANE_W'(PIXEL_BYTES - 1)) begin
                    r_lane <= '0;
                end else begin
                    r_lane <= r_lane + LANE_W'(1);
                end
            end
        end
    end

    // Forwarded byte for a read of the address written in the same cycle.
    always_ff @(posedge i_clk) begin
        r_byp_data <= res;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sample_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_out_byte    <= res;
            r_out_eor     <= eor;
            r_out_eoi     <= eoi;
            r_out_unknown <= unknown;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pixel_byte     = r_out_byte;
    assign o_end_of_row     = r_out_eor;
    assign o_end_of_image   = r_out_eoi;
    assign o_unknown_filter = r_out_unknown;

`ifndef SYNTHESIS
    // The last byte of an image is always the last byte of a row.
    a_eoi_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_image || o_end_of_row))
        else $error("end of image without end of row");

    // Waiting for a filter byte means the row position is back at its start.
    a_filter_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_filter |-> (r_pos == '0 && r_lane == '0))
        else $error("row position not cleared at filter byte");

    // The lane counter stays within one pixel.
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane <= LANE_W'(PIXEL_BYTES - 1))
        else $error("lane counter out of range");

    // A sample ending a row hands over to a filter byte next.
    a_eor_to_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample_acc && eor) |=> r_at_filter)
        else $error("row end did not return to filter byte");

    // A filter byte gives no result, so the output register does not load.
    a_filter_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_at_filter && !o_valid) |=> !o_valid)
        else $error("result produced for a filter byte");
`endif

endmodule
